### rtl/lru_kt_pkg.sv
// shared constants, types and state encoding for the lru key tracker
// no dependencies; imported by lru_key_tracker_core
package lru_kt_pkg;

    localparam int DEPTH    = 16;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CAP_W    = 5;
    localparam int KIND_W   = 2;
    localparam int OUT_KEY_W = 32;
    localparam int OCC_W    = 5;
    localparam int M_DATA_W = ((OUT_KEY_W + OCC_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_APPEND,
        ST_FINISH
    } lru_state_t;

endpackage

### rtl/lru_key_tracker_core.sv
// lru key tracker top level: sequencer, key memory and output register
// depends on lru_kt_pkg

// Keeps an ordered list of up to 16 keys, oldest first. Each item on the
// s_ channel (kind in s_tuser, key in s_tdata) gives one result on the m_
// channel. A load of a present key moves it to the newest end; a load of an
// absent key appends it, first evicting the oldest key when the list holds
// capacity keys or more. A lookup only reports presence, a clear empties the
// list. One key memory with a registered read port is scanned entry by entry
// by a single comparator, then the same port closes the gap one entry per
// cycle and one write appends the key. A lookup scans one entry per cycle and
// stops at the first hit or after the last entry. A load scans the same way,
// then shifts when it hits or evicts, and ends with one append. A clear, a
// no-op or an item on an empty list skips the scan. A stalled m_ channel
// holds the finished result in the sequencer until the output register is free.
// s_tready is high only while the sequencer is idle; a finished result waits
// in the output register so the next item can be accepted meanwhile. capacity
// is written through cfg_wr_en/cfg_wr_data; write it only while idle, as the
// block does not enforce this; 0 acts as 1 and values above 16 act as 16.
module lru_key_tracker_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration: capacity
    input  logic                           cfg_wr_en,
    input  logic [lru_kt_pkg::CAP_W-1:0]   cfg_wr_data,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // key[31:0]
    input  logic [lru_kt_pkg::KIND_W-1:0]  s_tuser,  // kind[1:0]
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lru_kt_pkg::M_DATA_W-1:0] m_tdata, // evicted_key[31:0], occupancy[36:32], zeros
    output logic [1:0]                     m_tuser   // hit[0], evicted_valid[1]
);
    import lru_kt_pkg::*;

    // sequencer and item context
    lru_state_t            state_reg, state_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CAP_W-1:0]      cap_reg;
    logic [CNT_W-1:0]      eff_cap;

    // scan / shift position and read pipeline tracking
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic [CNT_W-1:0]      scan_inc;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0]      wr_idx_reg, wr_idx_next;
    logic                  key_match;

    // result under construction
    logic                  hit_reg, hit_next;
    logic                  evict_reg, evict_next;
    logic [KEY_BITS-1:0]   evkey_reg, evkey_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;
    logic [1:0]            m_user_reg, m_user_next;

    // key memory, one write and one registered read per cycle
    logic [KEY_BITS-1:0]   key_mem [DEPTH];
    logic [KEY_BITS-1:0]   rd_data_reg;
    logic [IDX_W-1:0]      mem_ra;
    logic [IDX_W-1:0]      mem_wa;
    logic [KEY_BITS-1:0]   mem_wd;
    logic                  mem_we;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // capacity clamp: zero acts as one, above depth saturates
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CNT_W'(1);
        end else if (32'(cap_reg) > DEPTH) begin
            eff_cap = CNT_W'(DEPTH);
        end else begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    assign scan_inc  = scan_reg + CNT_W'(1);
    assign key_match = cmp_valid_reg && (rd_data_reg == key_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= key_mem[mem_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            cap_reg       <= CAP_W'(16);
            cmp_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmp_valid_reg <= cmp_valid_next;
            wr_pend_reg   <= wr_pend_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        wr_idx_reg  <= wr_idx_next;
        hit_reg     <= hit_next;
        evict_reg   <= evict_next;
        evkey_reg   <= evkey_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        wr_pend_next   = wr_pend_reg;
        wr_idx_next    = wr_idx_reg;
        hit_next       = hit_reg;
        evict_next     = evict_reg;
        evkey_next     = evkey_reg;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        mem_ra         = scan_reg[IDX_W-1:0];
        mem_we         = 1'b0;
        mem_wa         = wr_idx_reg;
        mem_wd         = rd_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next      = s_tuser;
                    key_next       = s_tdata[KEY_BITS-1:0];
                    hit_next       = 1'b0;
                    evict_next     = 1'b0;
                    scan_next      = '0;
                    cmp_valid_next = 1'b0;
                    wr_pend_next   = 1'b0;
                    case (s_tuser)
                        KIND_LOAD: begin
                            state_next = (cnt_reg == '0) ? ST_APPEND : ST_SEARCH;
                        end
                        KIND_LOOKUP: begin
                            state_next = (cnt_reg == '0) ? ST_FINISH : ST_SEARCH;
                        end
                        KIND_CLEAR: begin
                            cnt_next   = '0;
                            state_next = ST_FINISH;
                        end
                        default: begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_SEARCH: begin
                // read at scan_reg is issued now, compare the one issued last cycle
                if (cmp_valid_reg && cmp_idx_reg == '0) begin
                    evkey_next = rd_data_reg;  // oldest entry, kept for eviction
                end
                if (key_match) begin
                    hit_next       = 1'b1;
                    cmp_valid_next = 1'b0;
                    if (kind_reg == KIND_LOAD) begin
                        scan_next  = CNT_W'(cmp_idx_reg);
                        state_next = ST_SHIFT;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else if (!cmp_valid_reg && !(scan_reg < cnt_reg)) begin
                    // scan finished without a match
                    if (kind_reg == KIND_LOAD) begin
                        if (cnt_reg >= eff_cap) begin
                            evict_next = 1'b1;
                            scan_next  = '0;
                            state_next = ST_SHIFT;
                        end else begin
                            state_next = ST_APPEND;
                        end
                    end else begin
                        state_next = ST_FINISH;
                    end
                end else begin
                    cmp_valid_next = (scan_reg < cnt_reg);
                    cmp_idx_next   = scan_reg[IDX_W-1:0];
                    if (scan_reg < cnt_reg) begin
                        scan_next = scan_inc;
                    end
                end
            end

            ST_SHIFT: begin
                // read entry j+1 now, write it to j next cycle
                mem_ra = scan_inc[IDX_W-1:0];
                mem_we = wr_pend_reg;
                if (scan_inc < cnt_reg) begin
                    wr_pend_next = 1'b1;
                    wr_idx_next  = scan_reg[IDX_W-1:0];
                    scan_next    = scan_inc;
                end else begin
                    wr_pend_next = 1'b0;
                    if (!wr_pend_reg) begin
                        state_next = ST_APPEND;
                    end
                end
            end

            ST_APPEND: begin
                mem_we = 1'b1;
                mem_wd = key_reg;
                if (hit_reg || evict_reg) begin
                    mem_wa = IDX_W'(cnt_reg - CNT_W'(1));
                end else begin
                    mem_wa   = cnt_reg[IDX_W-1:0];
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = {evict_reg, hit_reg};
                    m_data_next  = M_DATA_W'({OCC_W'(cnt_reg),
                                   (evict_reg ? OUT_KEY_W'(evkey_reg) :
                                                {OUT_KEY_W{1'b0}})});
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // list never grows past the memory depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("key count exceeds depth");

    // an eviction is only reported on a miss
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("hit and eviction reported together");

    // memory is written only while shifting or appending
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_SHIFT || state_reg == ST_APPEND))
        else $error("memory write outside shift or append");

    // an accepted clear empties the list for its result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_CLEAR) |=> cnt_reg == '0)
        else $error("clear did not empty the list");
`endif

endmodule

### dv/lru_key_tracker_core_tb.sv
// self-checking testbench for lru_key_tracker_core: directed and random item streams
// depends on lru_kt_pkg and lru_key_tracker_core
`timescale 1ns / 1ps

module lru_key_tracker_core_tb;
    import lru_kt_pkg::*;

    // kind value that the block treats as a no-op
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
    // timeout and post-drain settle time, in clock cycles
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 48;
    localparam int KEY_POOL_SIZE = 24;

    // one expected result, as it leaves on the m_ channel
    typedef struct packed {
        logic                 hit;
        logic                 evicted_valid;
        logic [OUT_KEY_W-1:0] evicted_key;
        logic [OCC_W-1:0]     occupancy;
    } lru_result_t;

    logic                    aclk        = 1'b0;
    logic                    aresetn     = 1'b0;
    logic                    cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]        cfg_wr_data = '0;
    logic                    s_tvalid    = 1'b0;
    logic                    s_tready;
    logic [31:0]             s_tdata     = '0;
    logic [KIND_W-1:0]       s_tuser     = '0;
    logic                    m_tvalid;
    logic                    m_tready    = 1'b0;
    logic [M_DATA_W-1:0]     m_tdata;
    logic [1:0]              m_tuser;

    // shadow copy of the key list, oldest first
    logic [KEY_BITS-1:0]     shadow_keys [DEPTH];
    int                      shadow_count = 0;
    int                      shadow_capacity = 16;

    lru_result_t             pending_results [$];
    logic [31:0]             key_pool [KEY_POOL_SIZE];
    int                      error_count = 0;
    int                      cycle_count = 0;
    // percentages of cycles the sender idles and the receiver stalls
    int                      src_idle_pct = 0;
    int                      sink_stall_pct = 0;

    lru_key_tracker_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // key[31:0]
        .s_tuser     (s_tuser),     // kind[1:0]
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // evicted_key[31:0], occupancy[36:32], zeros
        .m_tuser     (m_tuser)      // hit[0], evicted_valid[1]
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // timeout watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver backpressure, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // drop the entry at pos and close the gap
    function automatic void shadow_remove(input int pos);
        int i;
        for (i = pos; i + 1 < shadow_count; i++)
            shadow_keys[i] = shadow_keys[i + 1];
        shadow_count--;
    endfunction

    function automatic void shadow_append(input logic [KEY_BITS-1:0] key);
        if (shadow_count < DEPTH) begin
            shadow_keys[shadow_count] = key;
            shadow_count++;
        end
    endfunction

    // apply one item to the shadow list and return the result it gives
    function automatic lru_result_t lru_update(input logic [KIND_W-1:0] kind,
                                               input logic [31:0] key);
        lru_result_t res;
        int          pos;
        int          eff_cap;
        int          i;
        res = '0;
        // capacity zero acts as one, anything above the depth saturates
        eff_cap = (shadow_capacity == 0) ? 1 :
                  (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
        pos = shadow_count;
        for (i = shadow_count - 1; i >= 0; i--)
            if (shadow_keys[i] == key)
                pos = i;
        case (kind)
            KIND_LOAD: begin
                if (pos < shadow_count) begin
                    // present: move to the newest end
                    res.hit = 1'b1;
                    shadow_remove(pos);
                end else if (shadow_count >= eff_cap && shadow_count > 0) begin
                    // absent and full: only the single oldest key goes,
                    // even when capacity was lowered below occupancy
                    res.evicted_valid = 1'b1;
                    res.evicted_key   = shadow_keys[0];
                    shadow_remove(0);
                end
                shadow_append(key);
            end
            KIND_LOOKUP: begin
                res.hit = (pos < shadow_count);
            end
            KIND_CLEAR: begin
                shadow_count = 0;
            end
            default: begin
            end
        endcase
        res.occupancy = shadow_count[OCC_W-1:0];
        return res;
    endfunction

    // result checker: every m_ transfer against the oldest expectation
    always @(posedge aclk) begin
        lru_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, actual tdata=%h tuser=%b",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tuser[0] !== exp_res.hit) begin
                    $display("%0t: hit mismatch, expected %b actual %b",
                             $time, exp_res.hit, m_tuser[0]);
                    error_count++;
                end
                if (m_tuser[1] !== exp_res.evicted_valid) begin
                    $display("%0t: evicted_valid mismatch, expected %b actual %b",
                             $time, exp_res.evicted_valid, m_tuser[1]);
                    error_count++;
                end
                if (m_tdata[31:0] !== exp_res.evicted_key) begin
                    $display("%0t: evicted_key mismatch, expected %h actual %h",
                             $time, exp_res.evicted_key, m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[36:32] !== exp_res.occupancy) begin
                    $display("%0t: occupancy mismatch, expected %0d actual %0d",
                             $time, exp_res.occupancy, m_tdata[36:32]);
                    error_count++;
                end
            end
        end
    end

    // send one item on the s_ channel; returns at the edge of the transfer
    // with tvalid still high, so the next call can go back to back
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [31:0] key);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= key;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_results = {pending_results, lru_update(kind, key)};
    endtask

    // stop sending, wait for every expected result, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // capacity is only written with the block idle
    task automatic write_capacity(input int value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value[CAP_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        shadow_capacity = value;
    endtask

    // mostly keys from a small pool so hits and evictions are frequent
    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 99) < 75)
            return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        return $urandom;
    endfunction

    task automatic run_random(input int num_items);
        int                n;
        int                roll;
        logic [KIND_W-1:0] kind;
        for (n = 0; n < num_items; n++) begin
            roll = $urandom_range(0, 999);
            // clears kept rare so the list gets to fill up
            if (roll < 600)
                kind = KIND_LOAD;
            else if (roll < 965)
                kind = KIND_LOOKUP;
            else if (roll < 985)
                kind = KIND_CLEAR;
            else
                kind = KIND_NOP;
            send_item(kind, pick_key());
        end
    endtask

    task automatic test_directed();
        // reset capacity of 16, extreme keys, every kind
        send_item(KIND_LOAD,   32'h0000_0000);
        send_item(KIND_LOAD,   32'hFFFF_FFFF);
        send_item(KIND_LOOKUP, 32'h0000_0000);
        send_item(KIND_LOOKUP, 32'h5A5A_5A5A);
        send_item(KIND_LOAD,   32'h0000_0000);
        send_item(KIND_NOP,    32'hFFFF_FFFF);
        send_item(KIND_LOOKUP, 32'hFFFF_FFFF);
        send_item(KIND_CLEAR,  32'hA5A5_A5A5);
        send_item(KIND_LOOKUP, 32'h0000_0000);
        // capacity zero behaves as one
        write_capacity(0);
        send_item(KIND_LOAD,   32'h0000_0001);
        send_item(KIND_LOAD,   32'h8000_0000);
        send_item(KIND_LOOKUP, 32'h8000_0000);
        send_item(KIND_LOAD,   32'h8000_0000);
        // grow to four, then lower capacity below occupancy
        write_capacity(4);
        send_item(KIND_LOAD,   32'h0000_0003);
        send_item(KIND_LOAD,   32'h7FFF_FFFF);
        send_item(KIND_LOAD,   32'hFFFF_FFFE);
        write_capacity(2);
        send_item(KIND_LOAD,   32'h1234_5678);
        send_item(KIND_LOAD,   32'h0000_0003);
        send_item(KIND_LOOKUP, 32'h8000_0000);
        // above the depth saturates to sixteen
        write_capacity(31);
        send_item(KIND_LOAD,   32'hDEAD_BEEF);
        send_item(KIND_CLEAR,  32'h0000_0000);
        send_item(KIND_NOP,    32'h0000_0000);
    endtask

    task automatic test_no_idle();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        write_capacity(16);
        run_random(200);
        write_capacity(1);
        run_random(175);
    endtask

    task automatic test_sender_idle();
        src_idle_pct   = 86;
        sink_stall_pct = 0;
        write_capacity(31);
        run_random(200);
        write_capacity(7);
        run_random(175);
    endtask

    task automatic test_receiver_stall();
        src_idle_pct   = 0;
        sink_stall_pct = 86;
        write_capacity(0);
        run_random(175);
        write_capacity(12);
        run_random(200);
    endtask

    task automatic test_both_idle();
        int ph;
        src_idle_pct   = 33;
        sink_stall_pct = 33;
        for (ph = 0; ph < 3; ph++) begin
            write_capacity($urandom_range(0, 31));
            run_random(125);
        end
    endtask

    initial begin
        int i;
        for (i = 0; i < KEY_POOL_SIZE; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        drain();

        if (error_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
